// ===== rtl/hsb_pkg.sv =====
// Shared types and constants for the hex string to bytes parser.
`default_nettype none
package hsb_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 8;

  localparam logic [CharW-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CharW-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR      = 8'h0D;
  localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CHAR_DASH    = 8'h2D;
  localparam logic [CharW-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CharW-1:0] LETTER_BASE  = 8'd10;

  localparam logic [IndexW-1:0] MAX_BYTES_RESET = 8'd8;

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_PARSE,
    MODE_DONE
  } parse_mode_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             string_start;
  } char_word_t;

  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_delim;
    logic       is_nul;
    logic [3:0] nibble;
  } char_class_t;

  typedef struct packed {
    logic              byte_valid;
    logic [IndexW-1:0] byte_index;
    logic [CharW-1:0]  byte_value;
    logic              done_res;
    logic              success;
    logic [IndexW-1:0] byte_count;
  } res_word_t;

endpackage
`default_nettype wire

// ===== rtl/hsb_ifs.sv =====
// Handshake interfaces for the character and result channels.
`default_nettype none
interface hsb_char_if;
  logic                      valid;
  logic                      ready;
  logic [hsb_pkg::CharW-1:0] char_code;
  logic                      string_start;

  modport source (output valid, output char_code, output string_start, input ready);
  modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

interface hsb_res_if;
  logic                       valid;
  logic                       ready;
  logic                       byte_valid;
  logic [hsb_pkg::IndexW-1:0] byte_index;
  logic [hsb_pkg::CharW-1:0]  byte_value;
  logic                       done_res;
  logic                       success;
  logic [hsb_pkg::IndexW-1:0] byte_count;

  modport source (output valid, output byte_valid, output byte_index, output byte_value,
                  output done_res, output success, output byte_count, input ready);
  modport sink   (input valid, input byte_valid, input byte_index, input byte_value,
                  input done_res, input success, input byte_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsb_char_class.sv =====
// Character classifier: whitespace, hex digit, delimiter, terminator and nibble value.
`default_nettype none
module hsb_char_class (
  input  wire logic [hsb_pkg::CharW-1:0] char_code_i,
  output hsb_pkg::char_class_t           class_o
);

  logic is_dec, is_lower, is_upper;
  logic [hsb_pkg::CharW-1:0] dec_val, lower_val, upper_val;

  always_comb begin
    is_dec   = (char_code_i >= hsb_pkg::CHAR_ZERO) && (char_code_i <= hsb_pkg::CHAR_NINE);
    is_lower = (char_code_i >= hsb_pkg::CHAR_LOWER_A) && (char_code_i <= hsb_pkg::CHAR_LOWER_F);
    is_upper = (char_code_i >= hsb_pkg::CHAR_UPPER_A) && (char_code_i <= hsb_pkg::CHAR_UPPER_F);

    dec_val   = char_code_i - hsb_pkg::CHAR_ZERO;
    lower_val = char_code_i - hsb_pkg::CHAR_LOWER_A + hsb_pkg::LETTER_BASE;
    upper_val = char_code_i - hsb_pkg::CHAR_UPPER_A + hsb_pkg::LETTER_BASE;

    class_o.is_space = (char_code_i == hsb_pkg::CHAR_SPACE)
                    || ((char_code_i >= hsb_pkg::CHAR_TAB) && (char_code_i <= hsb_pkg::CHAR_CR));
    class_o.is_digit = is_dec || is_lower || is_upper;
    class_o.is_delim = (char_code_i == hsb_pkg::CHAR_DASH)
                    || (char_code_i == hsb_pkg::CHAR_COLON);
    class_o.is_nul   = (char_code_i == hsb_pkg::CHAR_NUL);

    priority if (is_dec) begin
      class_o.nibble = dec_val[3:0];
    end else if (is_lower) begin
      class_o.nibble = lower_val[3:0];
    end else if (is_upper) begin
      class_o.nibble = upper_val[3:0];
    end else begin
      class_o.nibble = 4'd0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hsb_in_reg.sv =====
// Input register: holds one accepted character word until the parser takes it.
`default_nettype none
module hsb_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  hsb_char_if.sink             char_i,
  input  wire logic            advance_i,
  output logic                 valid_o,
  output hsb_pkg::char_word_t  word_o
);

  logic                valid_q, valid_d;
  hsb_pkg::char_word_t word_q;
  logic                accept;

  assign char_i.ready = !valid_q || advance_i;
  assign accept       = char_i.valid && char_i.ready;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.char_code    <= char_i.char_code;
      word_q.string_start <= char_i.string_start;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

// ===== rtl/hsb_parse.sv =====
// Parser state, per-character update and result register.
`default_nettype none
module hsb_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire hsb_pkg::char_word_t         word_i,
  input  wire hsb_pkg::char_class_t        class_i,
  input  wire logic [hsb_pkg::IndexW-1:0]  max_bytes_i,
  output logic                             advance_o,
  hsb_res_if.source                        res_o
);

  hsb_pkg::parse_mode_e mode_q, mode_d, mode_cur;
  logic [hsb_pkg::CharW-1:0]  acc_q, acc_d, acc_cur;
  logic [1:0]                 digits_q, digits_d, digits_cur;
  logic [hsb_pkg::IndexW-1:0] index_q, index_d, index_cur;
  logic                       last_dig_q, last_dig_d, last_dig_cur;

  logic                       res_valid_q, res_valid_d;
  hsb_pkg::res_word_t         res_q, res_d;

  logic active, ok_pre, ok, emit, done, good, has_result;

  // A start flag clears the state before this character is looked at.
  always_comb begin
    mode_cur     = word_i.string_start ? hsb_pkg::MODE_SKIP : mode_q;
    acc_cur      = word_i.string_start ? '0 : acc_q;
    digits_cur   = word_i.string_start ? '0 : digits_q;
    index_cur    = word_i.string_start ? '0 : index_q;
    last_dig_cur = word_i.string_start ? 1'b0 : last_dig_q;
  end

  // Next mode.
  always_comb begin
    unique case (mode_cur)
      hsb_pkg::MODE_SKIP:  mode_d = done ? hsb_pkg::MODE_DONE
                                  : (class_i.is_space ? hsb_pkg::MODE_SKIP : hsb_pkg::MODE_PARSE);
      hsb_pkg::MODE_PARSE: mode_d = done ? hsb_pkg::MODE_DONE : hsb_pkg::MODE_PARSE;
      hsb_pkg::MODE_DONE:  mode_d = hsb_pkg::MODE_DONE;
      default:             mode_d = hsb_pkg::MODE_DONE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    active = (mode_cur == hsb_pkg::MODE_PARSE)
          || ((mode_cur == hsb_pkg::MODE_SKIP) && !class_i.is_space);

    acc_d      = acc_cur;
    digits_d   = digits_cur;
    index_d    = index_cur;
    last_dig_d = last_dig_cur;
    emit       = 1'b0;
    done       = 1'b0;
    good       = 1'b0;
    ok         = 1'b0;

    ok_pre = (last_dig_cur && (class_i.is_nul || class_i.is_space || class_i.is_delim))
          || class_i.is_digit;

    if (active) begin
      last_dig_d = class_i.is_digit;
      ok         = ok_pre;
      if (ok_pre) begin
        // Close the current byte on a non-digit or on a third digit.
        if (!class_i.is_digit || (digits_cur == 2'd2)) begin
          emit     = 1'b1;
          index_d  = index_cur + 1'b1;
          digits_d = '0;
          acc_d    = '0;
        end
        if (class_i.is_digit) begin
          if (index_d < max_bytes_i) begin
            acc_d    = {acc_d[3:0], class_i.nibble};
            digits_d = digits_d + 1'b1;
          end else begin
            ok = 1'b0;
          end
        end else if (!class_i.is_delim) begin
          done = 1'b1;
          good = 1'b1;
        end
      end
      if (!ok) begin
        done = 1'b1;
      end
    end

    has_result = emit || done;

    res_d.byte_valid = emit;
    res_d.byte_index = emit ? index_cur : '0;
    res_d.byte_value = emit ? acc_cur : '0;
    res_d.done_res   = done;
    res_d.success    = good;
    res_d.byte_count = good ? index_d : '0;
  end

  // Move on unless a result must wait for a full, stalled output register.
  assign advance_o = valid_i && (!has_result || !res_valid_q || res_o.ready);

  always_comb begin
    if (advance_o && has_result) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hsb_pkg::MODE_SKIP;
      acc_q       <= '0;
      digits_q    <= '0;
      index_q     <= '0;
      last_dig_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (advance_o) begin
        mode_q     <= mode_d;
        acc_q      <= acc_d;
        digits_q   <= digits_d;
        index_q    <= index_d;
        last_dig_q <= last_dig_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && has_result) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.byte_valid = res_q.byte_valid;
  assign res_o.byte_index = res_q.byte_index;
  assign res_o.byte_value = res_q.byte_value;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.success    = res_q.success;
  assign res_o.byte_count = res_q.byte_count;

endmodule
`default_nettype wire

// ===== rtl/hex_string_to_bytes_parser.sv =====
// Top level of the hex string to bytes parser.
//
//   port        dir   handshake      payload
//   char_i      in    valid/ready    char_code[7:0], string_start
//   res_o       out   valid/ready    byte_valid, byte_index, byte_value,
//                                    done_res, success, byte_count
//   max_bytes_* in    write enable   max_bytes[7:0]
//
// One character word per cycle unless a stalled result register holds the parser;
// a word waits in the input register and its result, if any, is registered as it leaves.
// The input register refills while the result register still holds a word.
// A full, stalled result register stops only words that produce a result.
// Reset clears the parser to whitespace skipping and sets max_bytes to 8.
`default_nettype none
module hex_string_to_bytes_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  hsb_char_if.sink                        char_i,
  hsb_res_if.source                       res_o,
  input  wire logic                       max_bytes_we_i,
  input  wire logic [hsb_pkg::IndexW-1:0] max_bytes_i
);

  logic                       in_valid;
  hsb_pkg::char_word_t        in_word;
  hsb_pkg::char_class_t       char_class;
  logic                       advance;
  logic [hsb_pkg::IndexW-1:0] max_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= hsb_pkg::MAX_BYTES_RESET;
    end else if (max_bytes_we_i) begin
      max_bytes_q <= max_bytes_i;
    end
  end

  hsb_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .word_o    (in_word)
  );

  hsb_char_class u_char_class (
    .char_code_i (in_word.char_code),
    .class_o     (char_class)
  );

  hsb_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .word_i      (in_word),
    .class_i     (char_class),
    .max_bytes_i (max_bytes_q),
    .advance_o   (advance),
    .res_o       (res_o)
  );

  a_res_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.byte_valid || res_o.done_res))
    else $error("result word carries neither a byte nor an end");

  a_success_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.success) |-> res_o.done_res)
    else $error("success without done");

  a_count_on_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.success) |-> (res_o.byte_count == '0))
    else $error("nonzero byte count without success");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !advance) |=> (in_valid && $stable(in_word)))
    else $error("input word lost while parser stalled");

endmodule
`default_nettype wire
